/* sv/spatial_filter_3x3_defines.svh */
`ifndef SPATIAL_FILTER_3X3_DEFINES_SVH
`define SPATIAL_FILTER_3X3_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define SF3_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// condition that holds in the cycle after a trigger
`define SF3_ASSERT_NEXT(name, trig, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* sv/sf3_pkg.sv */
package sf3_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_HEIGHT     = 512;
  localparam int COEF_FRAC_BITS = 8;
  localparam int MIN_DIM        = 3;

  localparam int PIX_W  = 8;
  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
  localparam int LW_W   = 11;
  localparam int FH_W   = 10;
  localparam int LWR_W  = $clog2(MAX_WIDTH + 1);
  localparam int FHR_W  = $clog2(MAX_HEIGHT + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int Q_ONE   = 1 << COEF_FRAC_BITS;
  localparam int Q_MEAN  = (1111 * Q_ONE + 5000) / 10000;
  localparam int Q_BOOST = (52 * Q_ONE + 5) / 10;
  localparam int Q_GAUSS = Q_ONE / 16;
  localparam int Q_HALF  = Q_ONE / 2;

  localparam int COEF_W = COEF_FRAC_BITS + 4;
  localparam int OP_W   = 13;
  localparam int TERM_W = 11;
  localparam int PROD_W = COEF_W + OP_W;
  localparam int SUM_W  = COEF_FRAC_BITS + 12;
  localparam int SUMX_W = SUM_W + 1;

  localparam logic [LWR_W-1:0] RST_WIDTH  = LWR_W'((640 > MAX_WIDTH) ? MAX_WIDTH : 640);
  localparam logic [FHR_W-1:0] RST_HEIGHT = FHR_W'((480 > MAX_HEIGHT) ? MAX_HEIGHT : 480);

  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    KERN_MEAN    = 3'd0,
    KERN_GAUSS   = 3'd1,
    KERN_SOBEL_H = 3'd2,
    KERN_SOBEL_V = 3'd3,
    KERN_LAPLACE = 3'd4,
    KERN_BOOST   = 3'd5
  } kernel_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL = 2'd0,
    CFG_ABS    = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_reg_e;

  // one request as it enters the line memory stage
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic              wr;
    logic              top_lower;
    logic              bot_lower;
    logic              upd;
    logic              eol;
    logic              eof;
    logic              body;
    logic              first;
    logic [PIX_W-1:0]  px;
  } s1_ctl_t;

  typedef struct packed {
    logic eol;
    logic eof;
  } tag_t;

  // column of three pixels, index 0 is the top row
  typedef logic [2:0][PIX_W-1:0] col_t;
  // 3x3 window, [column][row], column 0 is the left one
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  function automatic logic [LWR_W-1:0] sat_width(input logic [LW_W-1:0] v);
    logic [LWR_W-1:0] r;
    if (int'(v) < MIN_DIM) begin
      r = LWR_W'(MIN_DIM);
    end else if (int'(v) > MAX_WIDTH) begin
      r = LWR_W'(MAX_WIDTH);
    end else begin
      r = LWR_W'(v);
    end
    return r;
  endfunction

  function automatic logic [FHR_W-1:0] sat_height(input logic [FH_W-1:0] v);
    logic [FHR_W-1:0] r;
    if (int'(v) < MIN_DIM) begin
      r = FHR_W'(MIN_DIM);
    end else if (int'(v) > MAX_HEIGHT) begin
      r = FHR_W'(MAX_HEIGHT);
    end else begin
      r = FHR_W'(v);
    end
    return r;
  endfunction

endpackage

/* sv/sf3_ctrl.sv */
`include "spatial_filter_3x3_defines.svh"

module sf3_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic                       req_type_i,
  input  logic [sf3_pkg::PIX_W-1:0]  pixel_i,
  input  logic                       restart_i,
  input  logic [sf3_pkg::LWR_W-1:0]  width_i,
  input  logic [sf3_pkg::FHR_W-1:0]  height_i,
  output sf3_pkg::s1_ctl_t           ctl_o
);

  logic [sf3_pkg::ADDR_W-1:0] col_q, col_d, c;
  logic [sf3_pkg::ROW_W-1:0]  row_q, row_d, r;
  logic                       flush, drain_ok, ignore, restart;

  always_comb begin
    flush    = (req_type_i == sf3_pkg::REQ_FLUSH);
    drain_ok = (int'(row_q) == int'(height_i))
            || ((int'(row_q) == int'(height_i) + 1) && (col_q == '0));
    ignore   = flush && !drain_ok;
    restart  = !flush && (int'(row_q) >= int'(height_i));
    r        = restart ? '0 : row_q;
    c        = restart ? '0 : col_q;

    ctl_o.valid     = fire_i && !ignore;
    ctl_o.addr      = c;
    ctl_o.wr        = int'(r) < int'(height_i);
    ctl_o.top_lower = int'(r) == 1;
    ctl_o.bot_lower = int'(r) == int'(height_i);
    ctl_o.upd       = int'(r) <= int'(height_i);
    ctl_o.eol       = (c == '0) && (int'(r) >= 2);
    ctl_o.eof       = int'(r) == int'(height_i) + 1;
    ctl_o.body      = (c != '0) && (r != '0) && (int'(r) <= int'(height_i));
    ctl_o.first     = int'(c) == 1;
    ctl_o.px        = pixel_i;

    col_d = col_q;
    row_d = row_q;
    if (ctl_o.valid) begin
      if (int'(c) + 1 >= int'(width_i)) begin
        col_d = '0;
        row_d = r + 1'b1;
      end else begin
        col_d = c + 1'b1;
        row_d = r;
      end
    end
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  `SF3_ASSERT(a_col_bound, int'(col_q) < int'(width_i), "column count past line width")
  `SF3_ASSERT(a_row_bound, int'(row_q) <= int'(height_i) + 1, "row count past drain row")
  `SF3_ASSERT_NEXT(a_flush_hold, fire_i && ignore && !restart_i, $stable(col_q) && $stable(row_q), "ignored flush moved counters")

endmodule

/* sv/sf3_line_buf.sv */
`include "spatial_filter_3x3_defines.svh"

module sf3_line_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  sf3_pkg::s1_ctl_t ctl_i,
  output logic             valid_o,
  output sf3_pkg::win_t    win_o,
  output sf3_pkg::tag_t    tag_o
);

  logic [sf3_pkg::PIX_W-1:0] upper_mem [sf3_pkg::MAX_WIDTH];
  logic [sf3_pkg::PIX_W-1:0] lower_mem [sf3_pkg::MAX_WIDTH];

  logic [sf3_pkg::PIX_W-1:0] rd_upper_q, rd_lower_q;
  sf3_pkg::s1_ctl_t          s1_q;
  sf3_pkg::col_t             w1_q, w2_q, newcol;
  sf3_pkg::win_t             win_d, win_q;
  sf3_pkg::tag_t             tag_d, tag_q;
  logic                      valid_q, step, wr_en;

  assign step  = adv_i && s1_q.valid;
  assign wr_en = step && s1_q.wr;

  // read one pixel per line, write back the shifted pair when the registered request steps on
  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      rd_upper_q <= upper_mem[ctl_i.addr];
      rd_lower_q <= lower_mem[ctl_i.addr];
    end
    if (wr_en) begin
      upper_mem[s1_q.addr] <= rd_lower_q;
      lower_mem[s1_q.addr] <= s1_q.px;
    end
  end

  always_comb begin
    newcol[0] = s1_q.top_lower ? rd_lower_q : rd_upper_q;
    newcol[1] = rd_lower_q;
    newcol[2] = s1_q.bot_lower ? rd_lower_q : s1_q.px;

    // replicate the edge column at line start and line end
    win_d[0] = s1_q.first ? w2_q : w1_q;
    win_d[1] = w2_q;
    win_d[2] = s1_q.eol ? w2_q : newcol;

    tag_d.eol = s1_q.eol;
    tag_d.eof = s1_q.eol && s1_q.eof;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q    <= '0;
      w1_q    <= '0;
      w2_q    <= '0;
      valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_q    <= ctl_i;
      valid_q <= s1_q.valid && (s1_q.eol || s1_q.body);
      if (step && s1_q.upd) begin
        w1_q <= w2_q;
        w2_q <= newcol;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      win_q <= win_d;
      tag_q <= tag_d;
    end
  end

  assign valid_o = valid_q;
  assign win_o   = win_q;
  assign tag_o   = tag_q;

  `SF3_ASSERT(a_one_result, !(s1_q.valid && s1_q.eol && s1_q.body), "two results for one request")

endmodule

/* sv/sf3_kernel.sv */
module sf3_kernel (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  sf3_pkg::win_t             win_i,
  input  sf3_pkg::tag_t             tag_i,
  input  sf3_pkg::kernel_e          kernel_i,
  input  logic                      abs_en_i,
  output logic                      valid_o,
  output logic [sf3_pkg::PIX_W-1:0] pix_o,
  output sf3_pkg::tag_t             tag_o
);

  // partial sums
  logic [11:0]        sall_d, sall_q;
  logic [9:0]         corners_d, corners_q, edges_d, edges_q;
  logic [9:0]         left_w, right_w, top_w, bot_w;
  logic [7:0]         center_q;
  logic signed [10:0] sobh_d, sobh_q, sobv_d, sobv_q;
  logic               a_valid_q;
  sf3_pkg::tag_t      a_tag_q;

  // weighted sum
  logic signed [sf3_pkg::COEF_W-1:0] cmul;
  logic signed [sf3_pkg::OP_W-1:0]   op;
  logic signed [sf3_pkg::TERM_W-1:0] term;
  logic signed [sf3_pkg::PROD_W-1:0] prod, term_x, full;
  logic signed [sf3_pkg::SUM_W-1:0]  sum_q;
  logic                              b_valid_q;
  sf3_pkg::tag_t                     b_tag_q;

  // round and clamp
  logic signed [sf3_pkg::SUM_W-1:0]  mag;
  logic [sf3_pkg::SUMX_W-1:0]        rnd;
  logic [sf3_pkg::PIX_W-1:0]         pix_d, pix_q;
  logic                              valid_q;
  sf3_pkg::tag_t                     tag_q;

  always_comb begin
    sall_d = 12'(win_i[0][0]) + 12'(win_i[1][0]) + 12'(win_i[2][0])
           + 12'(win_i[0][1]) + 12'(win_i[1][1]) + 12'(win_i[2][1])
           + 12'(win_i[0][2]) + 12'(win_i[1][2]) + 12'(win_i[2][2]);
    corners_d = 10'(win_i[0][0]) + 10'(win_i[2][0]) + 10'(win_i[0][2]) + 10'(win_i[2][2]);
    edges_d   = 10'(win_i[1][0]) + 10'(win_i[0][1]) + 10'(win_i[2][1]) + 10'(win_i[1][2]);
    left_w  = 10'(win_i[0][0]) + {1'b0, win_i[0][1], 1'b0} + 10'(win_i[0][2]);
    right_w = 10'(win_i[2][0]) + {1'b0, win_i[2][1], 1'b0} + 10'(win_i[2][2]);
    top_w   = 10'(win_i[0][0]) + {1'b0, win_i[1][0], 1'b0} + 10'(win_i[2][0]);
    bot_w   = 10'(win_i[0][2]) + {1'b0, win_i[1][2], 1'b0} + 10'(win_i[2][2]);
    sobh_d  = $signed({1'b0, right_w}) - $signed({1'b0, left_w});
    sobv_d  = $signed({1'b0, bot_w}) - $signed({1'b0, top_w});
  end

  always_comb begin
    term = '0;
    case (kernel_i)
      sf3_pkg::KERN_GAUSS: begin
        cmul = sf3_pkg::COEF_W'(sf3_pkg::Q_GAUSS);
        op   = $signed(sf3_pkg::OP_W'(corners_q) + sf3_pkg::OP_W'({edges_q, 1'b0})
                       + sf3_pkg::OP_W'({center_q, 2'b00}));
      end
      sf3_pkg::KERN_SOBEL_H: begin
        cmul = sf3_pkg::COEF_W'(sf3_pkg::Q_ONE);
        op   = sf3_pkg::OP_W'(sobh_q);
      end
      sf3_pkg::KERN_SOBEL_V: begin
        cmul = sf3_pkg::COEF_W'(sf3_pkg::Q_ONE);
        op   = sf3_pkg::OP_W'(sobv_q);
      end
      sf3_pkg::KERN_LAPLACE: begin
        cmul = sf3_pkg::COEF_W'(sf3_pkg::Q_ONE);
        op   = $signed(sf3_pkg::OP_W'({center_q, 2'b00})) - $signed(sf3_pkg::OP_W'(edges_q));
      end
      sf3_pkg::KERN_BOOST: begin
        cmul = sf3_pkg::COEF_W'(sf3_pkg::Q_BOOST);
        op   = $signed(sf3_pkg::OP_W'(center_q));
        term = -$signed({1'b0, edges_q});
      end
      default: begin
        cmul = sf3_pkg::COEF_W'(sf3_pkg::Q_MEAN);
        op   = $signed(sf3_pkg::OP_W'(sall_q));
      end
    endcase
    prod   = cmul * op;
    term_x = sf3_pkg::PROD_W'(term);
    full   = prod + (term_x <<< sf3_pkg::COEF_FRAC_BITS);
  end

  always_comb begin
    mag = sum_q;
    if (abs_en_i && sum_q < 0) begin
      mag = -sum_q;
    end
    rnd = (sf3_pkg::SUMX_W'(mag) + sf3_pkg::SUMX_W'(sf3_pkg::Q_HALF)) >> sf3_pkg::COEF_FRAC_BITS;
    if (mag <= 0) begin
      pix_d = '0;
    end else if (int'(rnd) > 255) begin
      pix_d = '1;
    end else begin
      pix_d = rnd[sf3_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      valid_q   <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      valid_q   <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sall_q    <= sall_d;
      corners_q <= corners_d;
      edges_q   <= edges_d;
      center_q  <= win_i[1][1];
      sobh_q    <= sobh_d;
      sobv_q    <= sobv_d;
      a_tag_q   <= tag_i;
      sum_q     <= full[sf3_pkg::SUM_W-1:0];
      b_tag_q   <= a_tag_q;
      pix_q     <= pix_d;
      tag_q     <= b_tag_q;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;
  assign tag_o   = tag_q;

endmodule

/* sv/spatial_filter_3x3.sv */
// 3x3 grey image filter, one pixel request per clock while m_axis is not stalled
// s_axis: tdata is the pixel, tuser high marks a flush request; pixels come in
//   raster order, line_width per line and frame_height lines per frame
// m_axis: tdata is the filtered pixel, tlast ends an output line, tuser marks
//   the last pixel of the frame
// cfg: index and data written when cfg_valid_i is high; ready is always high;
//   writes to the geometry registers restart the frame
// the first line_width + 1 pixels of a frame give no result, after that each
//   pixel completes one; after the last pixel, line_width + 1 flush requests
//   drain the bottom line, extra flushes are dropped
// a result passes the request, window, partial sum, sum and output registers to m_axis
// throughput is one request per clock while m_axis is not stalled, set by the single
//   read port and single write port of each line memory, used once per request
// reset clears counters, pipeline valids and the window, and loads the default
//   registers: mean kernel, abs on, 640 x 480; line memories are not cleared
// a stall on m_axis holds the whole pipeline; s_axis_tready drops only while the
//   output register is full and not taken
module spatial_filter_3x3 (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // pixel_in
  input  logic                            s_axis_tuser,   // req_type
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,   // pixel_out
  output logic                            m_axis_tlast,
  output logic                            m_axis_tuser,   // end_of_frame
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sf3_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sf3_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  sf3_pkg::kernel_e           kernel_q, kernel_d;
  logic                       abs_q, abs_d;
  logic [sf3_pkg::LWR_W-1:0]  width_q, width_d;
  logic [sf3_pkg::FHR_W-1:0]  height_q, height_d;
  logic                       cfg_fire, restart, adv, fire;

  sf3_pkg::s1_ctl_t           ctl;
  logic                       win_valid, out_valid;
  sf3_pkg::win_t              win;
  sf3_pkg::tag_t              win_tag, out_tag;
  logic [sf3_pkg::PIX_W-1:0]  out_pix;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_comb begin
    kernel_d = kernel_q;
    abs_d    = abs_q;
    width_d  = width_q;
    height_d = height_q;
    restart  = 1'b0;
    if (cfg_fire) begin
      case (cfg_index_i)
        sf3_pkg::CFG_KERNEL: kernel_d = sf3_pkg::kernel_e'(cfg_data_i[2:0]);
        sf3_pkg::CFG_ABS:    abs_d    = cfg_data_i[0];
        sf3_pkg::CFG_WIDTH: begin
          width_d = sf3_pkg::sat_width(cfg_data_i[sf3_pkg::LW_W-1:0]);
          restart = 1'b1;
        end
        sf3_pkg::CFG_HEIGHT: begin
          height_d = sf3_pkg::sat_height(cfg_data_i[sf3_pkg::FH_W-1:0]);
          restart  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q <= sf3_pkg::KERN_MEAN;
      abs_q    <= 1'b1;
      width_q  <= sf3_pkg::RST_WIDTH;
      height_q <= sf3_pkg::RST_HEIGHT;
    end else begin
      kernel_q <= kernel_d;
      abs_q    <= abs_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign fire          = s_axis_tvalid && adv;

  sf3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .req_type_i (s_axis_tuser),
    .pixel_i    (s_axis_tdata),
    .restart_i  (restart),
    .width_i    (width_q),
    .height_i   (height_q),
    .ctl_o      (ctl)
  );

  sf3_line_buf u_line_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .ctl_i   (ctl),
    .valid_o (win_valid),
    .win_o   (win),
    .tag_o   (win_tag)
  );

  sf3_kernel u_kernel (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (win_valid),
    .win_i    (win),
    .tag_i    (win_tag),
    .kernel_i (kernel_q),
    .abs_en_i (abs_q),
    .valid_o  (out_valid),
    .pix_o    (out_pix),
    .tag_o    (out_tag)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_pix;
  assign m_axis_tlast  = out_tag.eol;
  assign m_axis_tuser  = out_tag.eof;

endmodule

/* dv/spatial_filter_3x3_tb.sv */
`timescale 1ns / 100ps

module spatial_filter_3x3_tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic REQ_PIXEL   = ~sf3_pkg::REQ_FLUSH;

  // Q8 coefficients
  localparam int ONE_COEF   = 256;
  localparam int MEAN_COEF  = 28;
  localparam int GAUSS_COEF = 16;
  localparam int BOOST_COEF = 1331;

  // frame disturbances
  localparam int EARLY_FLUSH = 0;
  localparam int SHORT_DRAIN = 1;
  localparam int EXTRA_FLUSH = 2;

  typedef struct packed {
    logic       flush;
    logic [7:0] px;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] px;
    logic       eol;
    logic       eof;
  } pix_res_t;

  typedef logic [2:0][7:0] px_col_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata  = '0;
  logic                           s_axis_tuser  = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [7:0]                     m_axis_tdata;
  logic                           m_axis_tlast;
  logic                           m_axis_tuser;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [sf3_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [sf3_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  // filter state as the block should hold it
  logic [2:0] kern_sel = sf3_pkg::KERN_MEAN;
  logic       abs_on   = 1'b1;
  int         line_w   = 640;
  int         frame_h  = 480;
  int         col_cnt  = 0;
  int         row_cnt  = 0;
  logic [7:0] upper_line [sf3_pkg::MAX_WIDTH];
  logic [7:0] lower_line [sf3_pkg::MAX_WIDTH];
  px_col_t    win_cols [3];

  pix_req_t pixel_reqs [$];
  pix_res_t expected_pixels [$];
  pix_req_t next_req;
  pix_req_t seen_req;
  pix_res_t want_res;
  pix_res_t new_res;
  bit       new_emit;
  logic     req_taken   = 1'b0;
  int       idle_pct    = 0;
  int       stall_pct   = 0;
  int       items_queued   = 0;
  int       reqs_accepted  = 0;
  int       results_checked = 0;
  int       mismatch_count = 0;
  int       cycle_count    = 0;

  spatial_filter_3x3 DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < sf3_pkg::MAX_WIDTH; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      win_cols[i] = '0;
    end
  end

  function automatic int kernel_coef(int pos);
    int sobel_h [9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
    int sobel_v [9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
    int laplace [9] = '{0, -1, 0, -1, 4, -1, 0, -1, 0};
    int gauss   [9] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
    case (kern_sel)
      sf3_pkg::KERN_GAUSS:   return gauss[pos] * GAUSS_COEF;
      sf3_pkg::KERN_SOBEL_H: return sobel_h[pos] * ONE_COEF;
      sf3_pkg::KERN_SOBEL_V: return sobel_v[pos] * ONE_COEF;
      sf3_pkg::KERN_LAPLACE: return laplace[pos] * ONE_COEF;
      sf3_pkg::KERN_BOOST:   return (pos == 4) ? BOOST_COEF : laplace[pos] * ONE_COEF;
      default:               return MEAN_COEF;
    endcase
  endfunction

  function automatic logic [7:0] window_sum(px_col_t left, px_col_t mid, px_col_t right);
    px_col_t cols [3];
    int acc;
    acc = 0;
    cols[0] = left;
    cols[1] = mid;
    cols[2] = right;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        acc += kernel_coef(r * 3 + c) * int'(cols[c][r]);
      end
    end
    if (abs_on && acc < 0) acc = -acc;
    if (acc <= 0) return 8'd0;
    acc = (acc + ONE_COEF / 2) >>> 8;
    return (acc > 255) ? 8'd255 : 8'(acc);
  endfunction

  task automatic predict_pixel(input pix_req_t rq, output bit emit, output pix_res_t res);
    int r;
    int c;
    logic [7:0] top;
    logic [7:0] midp;
    logic [7:0] bot;
    emit = 1'b0;
    res  = '0;
    if (rq.flush != sf3_pkg::REQ_FLUSH) begin
      if (row_cnt >= frame_h) begin
        row_cnt = 0;
        col_cnt = 0;
      end
    end else if (!(row_cnt == frame_h || (row_cnt == frame_h + 1 && col_cnt == 0))) begin
      return;
    end
    r = row_cnt;
    c = col_cnt;
    if (c >= line_w || c >= sf3_pkg::MAX_WIDTH) c = 0;
    // column 0 closes the previous line with the right edge replicated
    if (c == 0 && r >= 2) begin
      res.px  = window_sum(win_cols[1], win_cols[2], win_cols[2]);
      res.eol = 1'b1;
      res.eof = (r == frame_h + 1);
      emit    = 1'b1;
    end
    if (r <= frame_h) begin
      top  = (r == 1) ? lower_line[c] : upper_line[c];
      midp = lower_line[c];
      bot  = (r == frame_h) ? lower_line[c] : rq.px;
      win_cols[0] = win_cols[1];
      win_cols[1] = win_cols[2];
      win_cols[2][0] = top;
      win_cols[2][1] = midp;
      win_cols[2][2] = bot;
      if (r < frame_h) begin
        upper_line[c] = lower_line[c];
        lower_line[c] = rq.px;
      end
      if (c >= 1 && r >= 1) begin
        res.px = window_sum((c == 1) ? win_cols[1] : win_cols[0], win_cols[1], win_cols[2]);
        emit   = 1'b1;
      end
    end
    col_cnt = c + 1;
    if (col_cnt >= line_w) begin
      col_cnt = 0;
      row_cnt = r + 1;
    end
  endtask

  function automatic int clamp_dim(int v, int hi);
    if (v < sf3_pkg::MIN_DIM) return sf3_pkg::MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("mismatch in %s at result %0d: got %0d, expected %0d",
             what, results_checked, got, want);
  endtask

  // request driver
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (pixel_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_req = pixel_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_req.px;
        s_axis_tuser  <= next_req.flush;
      end else begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom);
      end
    end
  end

  // monitor: check results, then predict for the request taken at this edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected result pixel", m_axis_tdata, -1);
        end else begin
          want_res = expected_pixels.pop_front();
          if (m_axis_tdata !== want_res.px)
            report_mismatch("pixel_out", m_axis_tdata, want_res.px);
          if (m_axis_tlast !== want_res.eol)
            report_mismatch("end_of_line", m_axis_tlast, want_res.eol);
          if (m_axis_tuser !== want_res.eof)
            report_mismatch("end_of_frame", m_axis_tuser, want_res.eof);
        end
        results_checked++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen_req.flush = s_axis_tuser;
        seen_req.px    = s_axis_tdata;
        predict_pixel(seen_req, new_emit, new_res);
        if (new_emit) expected_pixels.push_back(new_res);
        reqs_accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_pixels.size());
      $display("spatial_filter_3x3_tb failed");
      $finish;
    end
  end

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_req(logic flush, logic [7:0] px);
    pix_req_t rq;
    rq.flush = flush;
    rq.px    = px;
    pixel_reqs.push_back(rq);
    items_queued++;
  endtask

  task automatic write_reg(sf3_pkg::cfg_reg_e idx, int value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= sf3_pkg::CFG_DATA_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sf3_pkg::CFG_KERNEL: kern_sel = value[2:0];
      sf3_pkg::CFG_ABS:    abs_on   = value[0];
      sf3_pkg::CFG_WIDTH: begin
        line_w  = clamp_dim(value & 'h7FF, sf3_pkg::MAX_WIDTH);
        col_cnt = 0;
        row_cnt = 0;
      end
      default: begin
        frame_h = clamp_dim(value & 'h3FF, sf3_pkg::MAX_HEIGHT);
        col_cnt = 0;
        row_cnt = 0;
      end
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pixel_reqs.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one frame in raster order plus its drain, optionally disturbed
  task automatic queue_frame(bit noisy);
    int style;
    int drain;
    int early_at;
    style    = noisy ? $urandom_range(9) : 9;
    drain    = line_w + 1;
    early_at = (style == EARLY_FLUSH) ? $urandom_range(line_w * frame_h - 1) : -1;
    if (style == SHORT_DRAIN) drain = $urandom_range(line_w);
    if (style == EXTRA_FLUSH) drain = line_w + 1 + $urandom_range(3, 1);
    for (int i = 0; i < line_w * frame_h; i++) begin
      if (i == early_at) push_req(sf3_pkg::REQ_FLUSH, 8'($urandom));
      push_req(REQ_PIXEL, rand_pixel());
    end
    repeat (drain) push_req(sf3_pkg::REQ_FLUSH, 8'($urandom));
  endtask

  initial begin
    int stop_at;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // checkerboard on the smallest image with the reset kernel, plus stray flushes
    write_reg(sf3_pkg::CFG_WIDTH, 3);
    write_reg(sf3_pkg::CFG_HEIGHT, 3);
    push_req(REQ_PIXEL, 8'd0);
    push_req(REQ_PIXEL, 8'd255);
    push_req(sf3_pkg::REQ_FLUSH, 8'd255);
    push_req(REQ_PIXEL, 8'd0);
    push_req(REQ_PIXEL, 8'd255);
    push_req(REQ_PIXEL, 8'd0);
    push_req(REQ_PIXEL, 8'd255);
    push_req(REQ_PIXEL, 8'd0);
    push_req(REQ_PIXEL, 8'd255);
    push_req(REQ_PIXEL, 8'd0);
    repeat (5) push_req(sf3_pkg::REQ_FLUSH, 8'd0);
    wait_idle();

    // every kernel code, abs alternating
    for (int k = 0; k < 8; k++) begin
      write_reg(sf3_pkg::CFG_KERNEL, k);
      write_reg(sf3_pkg::CFG_ABS, k & 1);
      queue_frame(1'b0);
      wait_idle();
    end

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 67; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      repeat (2) begin
        write_reg(sf3_pkg::CFG_KERNEL, $urandom_range(7));
        write_reg(sf3_pkg::CFG_ABS, $urandom_range(1));
        write_reg(sf3_pkg::CFG_WIDTH, $urandom_range(8, 3));
        write_reg(sf3_pkg::CFG_HEIGHT, $urandom_range(5, 3));
        stop_at = items_queued + 16;
        while (items_queued < stop_at) queue_frame(1'b1);
        wait_idle();
      end
    end

    // geometry reached through saturating writes, part of a tall frame
    write_reg(sf3_pkg::CFG_KERNEL, $urandom_range(7));
    write_reg(sf3_pkg::CFG_ABS, $urandom_range(1));
    write_reg(sf3_pkg::CFG_WIDTH, 1);
    write_reg(sf3_pkg::CFG_HEIGHT, 1023);
    repeat (15) push_req(REQ_PIXEL, rand_pixel());
    wait_idle();

    $display("%0d requests taken, %0d filtered pixels checked, %0d mismatches",
             reqs_accepted, results_checked, mismatch_count);
    $display("covered all kernel codes, abs on and off, small frames with flush noise");
    if (mismatch_count == 0) begin
      $display("spatial_filter_3x3_tb passed");
    end else begin
      $display("spatial_filter_3x3_tb failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/sf3_pkg.sv
sv/sf3_ctrl.sv
sv/sf3_line_buf.sv
sv/sf3_kernel.sv
sv/spatial_filter_3x3.sv
dv/spatial_filter_3x3_tb.sv
